// ===== hw/rtl/svang_pkg.sv =====
// shared constants, types and helper functions for the signed vector angle block
// no dependencies
package svang_pkg;

  localparam int COORD_BITS      = 32;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;

  localparam int FRONT_STAGES = 6;
  localparam int QDEPTH       = 8;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int SQRT_STEPS   = 32;
  localparam int XW           = 36;
  localparam int ZW           = 35;
  localparam int ROUND_SHIFT  = 30 - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

  typedef struct packed {
    logic        deg;
    logic        use_n;
    logic        negate;
    logic        dneg;
    logic [29:0] xm;
    logic [29:0] q0;
    logic [29:0] q1;
    logic [29:0] q2;
  } svang_item_t;

  typedef struct packed {
    logic        deg;
    logic        use_n;
    logic        negate;
    logic        dneg;
    logic [29:0] xm;
  } svang_side_t;

  function automatic logic signed [31:0] coord(input logic [31:0] v);
    return $signed(v << (32 - COORD_BITS)) >>> (32 - COORD_BITS);
  endfunction

  function automatic logic [5:0] norm_shift(input logic [63:0] m);
    int len;
    len = 0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) len = k + 1;
    end
    return (len > 30) ? 6'(len - 30) : 6'd0;
  endfunction

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    case (i)
      0:  return 35'sd843314857;
      1:  return 35'sd497837829;
      2:  return 35'sd263043837;
      3:  return 35'sd133525159;
      4:  return 35'sd67021687;
      5:  return 35'sd33543516;
      6:  return 35'sd16775851;
      7:  return 35'sd8388437;
      8:  return 35'sd4194283;
      9:  return 35'sd2097149;
      10: return 35'sd1048576;
      11: return 35'sd524288;
      12: return 35'sd262144;
      13: return 35'sd131072;
      14: return 35'sd65536;
      15: return 35'sd32768;
      16: return 35'sd16384;
      17: return 35'sd8192;
      18: return 35'sd4096;
      19: return 35'sd2048;
      20: return 35'sd1024;
      21: return 35'sd512;
      22: return 35'sd256;
      23: return 35'sd128;
      24: return 35'sd64;
      25: return 35'sd32;
      26: return 35'sd16;
      27: return 35'sd8;
      28: return 35'sd4;
      29: return 35'sd2;
      30: return 35'sd1;
      default: return 35'sd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/signed_vector_angle.sv =====
// top level of the signed angle between two 3d vectors
// depends on svang_pkg, svang_front, svang_queue, svang_back
//
// One item per clock: start is taken whenever busy is low, and busy stays low
// in steady streaming since the back pipeline drains the queue every cycle.
// Each result is on the result ports and is taken, in order, on a single cycle
// done strobe that cannot be held off. The path runs through the six front
// stages, the queue memory and its read register, two squaring stages, the
// 32-stage square root of the cross magnitude and the 17 cordic stages plus
// output register, the first of these registers loading at the accepting edge
// itself.
// zero_limit is written with zero_limit_we and should only change while idle.
module signed_vector_angle import svang_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        a_x,
  input  logic [31:0]        a_y,
  input  logic [31:0]        a_z,
  input  logic [31:0]        b_x,
  input  logic [31:0]        b_y,
  input  logic [31:0]        b_z,
  input  logic [31:0]        n_x,
  input  logic [31:0]        n_y,
  input  logic [31:0]        n_z,
  input  logic               zero_limit_we,
  input  logic [31:0]        zero_limit,
  output logic               done,
  output logic signed [15:0] angle,
  output logic               degenerate,
  output logic               sign_applied
);

  logic [31:0]       zl;
  logic              f_valid, q_valid;
  svang_item_t       f_item, q_item;
  logic [QPTR_W:0]   q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      zl <= '0;
    end else if (zero_limit_we) begin
      zl <= zero_limit;
    end
  end

  // leave room in the queue for every beat still in the front
  assign busy = q_count >= (QPTR_W+1)'(QDEPTH - FRONT_STAGES);

  svang_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .n_x        (n_x),
    .n_y        (n_y),
    .n_z        (n_z),
    .zero_limit (zl),
    .out_valid  (f_valid),
    .out_item   (f_item)
  );

  svang_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .count     (q_count)
  );

  svang_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_item      (q_item),
    .done         (done),
    .angle        (angle),
    .degenerate   (degenerate),
    .sign_applied (sign_applied)
  );

endmodule

// ===== hw/rtl/svang_front.sv =====
// front pipeline: exact products, zero tests, orientation sign and common scaling
// depends on svang_pkg
module svang_front import svang_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        a_x,
  input  logic [31:0]        a_y,
  input  logic [31:0]        a_z,
  input  logic [31:0]        b_x,
  input  logic [31:0]        b_y,
  input  logic [31:0]        b_z,
  input  logic [31:0]        n_x,
  input  logic [31:0]        n_y,
  input  logic [31:0]        n_z,
  input  logic [31:0]        zero_limit,
  output logic               out_valid,
  output svang_item_t        out_item
);

  logic [FRONT_STAGES-1:0] vld;

  // stage 0
  logic signed [31:0] ax, ay, az, bx, by, bz, nx0, ny0, nz0;
  // stage 1
  logic signed [63:0] sa0, sa1, sa2, sb0, sb1, sb2, sn0, sn1, sn2;
  logic signed [63:0] d0, d1, d2, p0, p1, p2, p3, p4, p5;
  logic signed [31:0] nx1, ny1, nz1;
  // stage 2
  logic [63:0]        la, lb, ln;
  logic signed [65:0] dot;
  logic signed [63:0] c0, c1, c2;
  logic signed [31:0] nx2, ny2, nz2;
  // stage 3
  logic               deg3, usen3, dneg3;
  logic [63:0]        dm3, cm0, cm1, cm2;
  logic signed [63:0] ph0, ph1, ph2;
  logic signed [64:0] pl0, pl1, pl2;
  // stage 4
  logic               deg4, usen4, dneg4, neg4;
  logic [63:0]        dm4, cq0, cq1, cq2;
  logic [5:0]         s4;
  logic signed [98:0] trip;

  assign trip = ((99'(ph0) + 99'(ph1) + 99'(ph2)) <<< 32) + 99'(pl0) + 99'(pl1) + 99'(pl2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ax  <= coord(a_x);
    ay  <= coord(a_y);
    az  <= coord(a_z);
    bx  <= coord(b_x);
    by  <= coord(b_y);
    bz  <= coord(b_z);
    nx0 <= coord(n_x);
    ny0 <= coord(n_y);
    nz0 <= coord(n_z);

    sa0 <= ax * ax;
    sa1 <= ay * ay;
    sa2 <= az * az;
    sb0 <= bx * bx;
    sb1 <= by * by;
    sb2 <= bz * bz;
    sn0 <= nx0 * nx0;
    sn1 <= ny0 * ny0;
    sn2 <= nz0 * nz0;
    d0  <= ax * bx;
    d1  <= ay * by;
    d2  <= az * bz;
    p0  <= ay * bz;
    p1  <= az * by;
    p2  <= az * bx;
    p3  <= ax * bz;
    p4  <= ax * by;
    p5  <= ay * bx;
    nx1 <= nx0;
    ny1 <= ny0;
    nz1 <= nz0;

    la  <= sa0 + sa1 + sa2;
    lb  <= sb0 + sb1 + sb2;
    ln  <= sn0 + sn1 + sn2;
    dot <= 66'(d0) + 66'(d1) + 66'(d2);
    c0  <= p0 - p1;
    c1  <= p2 - p3;
    c2  <= p4 - p5;
    nx2 <= nx1;
    ny2 <= ny1;
    nz2 <= nz1;

    deg3  <= (la <= {32'd0, zero_limit}) || (lb <= {32'd0, zero_limit});
    usen3 <= ln > {32'd0, zero_limit};
    dneg3 <= dot[65];
    dm3   <= dot[65] ? 64'(-dot) : dot[63:0];
    cm0   <= c0[63] ? 64'(-c0) : c0;
    cm1   <= c1[63] ? 64'(-c1) : c1;
    cm2   <= c2[63] ? 64'(-c2) : c2;
    ph0   <= $signed(c0[63:32]) * nx2;
    ph1   <= $signed(c1[63:32]) * ny2;
    ph2   <= $signed(c2[63:32]) * nz2;
    pl0   <= $signed({1'b0, c0[31:0]}) * nx2;
    pl1   <= $signed({1'b0, c1[31:0]}) * ny2;
    pl2   <= $signed({1'b0, c2[31:0]}) * nz2;

    deg4  <= deg3;
    usen4 <= usen3;
    dneg4 <= dneg3;
    neg4  <= usen3 & trip[98];
    dm4   <= dm3;
    cq0   <= cm0;
    cq1   <= cm1;
    cq2   <= cm2;
    s4    <= norm_shift(dm3 | cm0 | cm1 | cm2);

    out_item.deg    <= deg4;
    out_item.use_n  <= usen4;
    out_item.negate <= neg4;
    out_item.dneg   <= dneg4;
    out_item.xm     <= 30'(dm4 >> s4);
    out_item.q0     <= 30'(cq0 >> s4);
    out_item.q1     <= 30'(cq1 >> s4);
    out_item.q2     <= 30'(cq2 >> s4);
  end

  assign out_valid = vld[FRONT_STAGES-1];

endmodule

// ===== hw/rtl/svang_queue.sv =====
// short queue between the front and back pipelines, drained whenever it holds a beat
// depends on svang_pkg
module svang_queue import svang_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  svang_item_t        push_item,
  output logic               pop_valid,
  output svang_item_t        pop_item,
  output logic [QPTR_W:0]    count
);

  svang_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic                pop;

  assign pop = count != '0;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
    if (pop) pop_item <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      pop_valid <= 1'b0;
    end else begin
      pop_valid <= pop;
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != (QPTR_W+1)'(QDEPTH)))
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/svang_back.sv =====
// back pipeline: cross magnitude square root, vectoring cordic, rounding and sign
// depends on svang_pkg
module svang_back import svang_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  svang_item_t        in_item,
  output logic               done,
  output logic signed [15:0] angle,
  output logic               degenerate,
  output logic               sign_applied
);

  logic              vb1, vb2;
  svang_side_t       side1, side2;
  logic [59:0]       sq0, sq1, sq2;
  logic [61:0]       v2;

  logic              sq_vld  [SQRT_STEPS+1];
  svang_side_t       sq_side [SQRT_STEPS+1];
  logic [63:0]       sq_rem  [SQRT_STEPS+1];
  logic [63:0]       sq_root [SQRT_STEPS+1];

  logic                 c_vld  [CORDIC_STEPS+1];
  svang_side_t          c_side [CORDIC_STEPS+1];
  logic                 c_par  [CORDIC_STEPS+1];
  logic signed [XW-1:0] cx     [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy     [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz     [CORDIC_STEPS+1];

  logic [30:0]          r_fin;
  logic signed [XW-1:0] xmag;
  logic signed [ZW-1:0] zc;
  logic [ZW-1:0]        zr;
  logic [15:0]          amag;
  svang_side_t          fs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
    end else begin
      vb1 <= in_valid;
      vb2 <= vb1;
    end
  end

  always_ff @(posedge clk) begin
    side1 <= '{deg: in_item.deg, use_n: in_item.use_n, negate: in_item.negate,
               dneg: in_item.dneg, xm: in_item.xm};
    sq0   <= in_item.q0 * in_item.q0;
    sq1   <= in_item.q1 * in_item.q1;
    sq2   <= in_item.q2 * in_item.q2;
    side2 <= side1;
    v2    <= 62'(sq0) + 62'(sq1) + 62'(sq2);
  end

  assign sq_vld[0]  = vb2;
  assign sq_side[0] = side2;
  assign sq_rem[0]  = 64'(v2);
  assign sq_root[0] = '0;

  // one result bit of the square root per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sq_root[j] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j+1] <= 1'b0;
      end else begin
        sq_vld[j+1] <= sq_vld[j];
      end
    end
    always_ff @(posedge clk) begin
      sq_side[j+1] <= sq_side[j];
      if (sq_rem[j] >= trial) begin
        sq_rem[j+1]  <= sq_rem[j] - trial;
        sq_root[j+1] <= (sq_root[j] >> 1) + BIT;
      end else begin
        sq_rem[j+1]  <= sq_rem[j];
        sq_root[j+1] <= sq_root[j] >> 1;
      end
    end
  end

  assign r_fin = sq_root[SQRT_STEPS][30:0];
  assign xmag  = XW'({1'b0, sq_side[SQRT_STEPS].xm});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else begin
      c_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end

  // rotate into the right half plane first when the dot product is negative and its scaled magnitude is nonzero
  always_ff @(posedge clk) begin
    c_side[0] <= sq_side[SQRT_STEPS];
    c_par[0]  <= r_fin == '0;
    if (sq_side[SQRT_STEPS].dneg && sq_side[SQRT_STEPS].xm != '0) begin
      cx[0] <= XW'({1'b0, r_fin});
      cy[0] <= xmag;
      cz[0] <= HALF_PI_Q30;
    end else begin
      cx[0] <= xmag;
      cy[0] <= XW'({1'b0, r_fin});
      cz[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld[i+1] <= 1'b0;
      end else begin
        c_vld[i+1] <= c_vld[i];
      end
    end
    always_ff @(posedge clk) begin
      c_side[i+1] <= c_side[i];
      c_par[i+1]  <= c_par[i];
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + atan_q30(i);
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - atan_q30(i);
      end
    end
  end

  assign fs = c_side[CORDIC_STEPS];

  always_comb begin
    if (c_par[CORDIC_STEPS]) begin
      zc = fs.dneg ? PI_Q30 : '0;
    end else if (cz[CORDIC_STEPS] < 0) begin
      zc = '0;
    end else if (cz[CORDIC_STEPS] > PI_Q30) begin
      zc = PI_Q30;
    end else begin
      zc = cz[CORDIC_STEPS];
    end
    zr   = ZW'(zc) + (ZW'(1) << (ROUND_SHIFT - 1));
    amag = 16'(zr >> ROUND_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (fs.deg) begin
      angle        <= '0;
      degenerate   <= 1'b1;
      sign_applied <= 1'b0;
    end else begin
      angle        <= fs.negate ? -$signed(amag) : $signed(amag);
      degenerate   <= 1'b0;
      sign_applied <= fs.use_n;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> angle == '0 && !sign_applied)
    else $error("degenerate beat with nonzero angle or sign");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> angle <= 16'sd25736 && angle >= -16'sd25736)
    else $error("angle outside minus pi to pi");

endmodule
